// ===== rtl/dqr_pkg.sv =====
// Shared types and constants for the DNS query redirect responder.
// No dependencies; imported by dqr_parser and dns_query_redirect_responder.
package dqr_pkg;

	localparam int HEADER_BYTES = 12;
	localparam int ANSWER_BYTES = 16;
	localparam int ANS_IDX_W    = $clog2(ANSWER_BYTES);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LABEL_LEN,
		PH_LABEL_BODY,
		PH_TAIL,
		PH_DONE,
		PH_FAILED
	} phase_t;

	// What follows the (optional) passed-through byte of one query byte
	typedef enum logic [1:0] {
		TAIL_NONE,
		TAIL_ANSWER,
		TAIL_DROP
	} tail_t;

	typedef struct packed {
		logic        has_byte;
		logic [7:0]  data;
		tail_t       tail;
	} job_t;

	// Appended A record: name pointer to offset 12, type A, class IN, TTL 30, rdlength 4
	function automatic logic [7:0] answer_byte(logic [ANS_IDX_W-1:0] idx, logic [31:0] ip);
		logic [7:0] b;
		b = 8'h00;
		case (idx)
			4'd0:    b = 8'hC0;
			4'd1:    b = 8'h0C;
			4'd3:    b = 8'h01;
			4'd5:    b = 8'h01;
			4'd9:    b = 8'h1E;
			4'd11:   b = 8'h04;
			4'd12:   b = ip[31:24];
			4'd13:   b = ip[23:16];
			4'd14:   b = ip[15:8];
			4'd15:   b = ip[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/dns_query_redirect_responder.sv =====
// DNS query redirect responder, top level.
// Depends on dqr_pkg and dqr_parser.
//
// Usage: query bytes enter on query_byte/end_of_query with query_valid/query_stall;
// reply items leave on reply_byte/end_of_reply/dropped with reply_valid/reply_stall.
// A transfer happens on a rising edge with valid high and stall low.
// Each query byte gives zero or one reply byte. The byte marked end_of_query
// additionally gives either the 16-byte A record (last byte flagged
// end_of_reply) or a single item with end_of_reply and dropped set.
// A query byte's reply item is loaded into the parse register at its transfer and then
// moves into the output register.
// Throughput is one byte per cycle while no stall holds it. After a final byte query_stall
// stays high while its trailing items drain one per cycle when reply_stall allows
// (the 16-byte answer, or a drop item that follows a passed byte), and whenever a held
// reply item meets reply_stall.
// A stalled reply item holds; the parse register then fills and stalls input.
// The user must write gateway_ip (cfg_wr_en/cfg_wr_data) only while idle; unenforced.
// Reset clears the parse state, all valid flags and gateway_ip to 0.
module dns_query_redirect_responder #(
	parameter int PACKET_BUFFER_BYTES = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        query_valid,
	output logic        query_stall,
	input  logic [7:0]  query_byte,
	input  logic        end_of_query,
	output logic        reply_valid,
	input  logic        reply_stall,
	output logic [7:0]  reply_byte,
	output logic        end_of_reply,
	output logic        dropped,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);
	import dqr_pkg::*;

	localparam int QUERY_LIMIT = PACKET_BUFFER_BYTES - ANSWER_BYTES;

	logic [31:0]          gateway_ip_q;
	job_t                 job;
	logic                 accept;
	logic                 job_v_s1;
	job_t                 job_s1;
	logic [ANS_IDX_W-1:0] ans_idx_s1;
	logic                 out_free, move, piece_last, done;
	logic [7:0]           item_byte;
	logic                 item_end, item_drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gateway_ip_q <= '0;
		else if (cfg_wr_en)
			gateway_ip_q <= cfg_wr_data;
	end

	dqr_parser #(
		.QUERY_LIMIT(QUERY_LIMIT)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (accept),
		.query_byte   (query_byte),
		.end_of_query (end_of_query),
		.job          (job)
	);

	// Pick the next item of the held job
	always_comb begin
		item_byte  = 8'h00;
		item_end   = 1'b0;
		item_drop  = 1'b0;
		piece_last = 1'b0;
		if (job_s1.has_byte) begin
			item_byte  = job_s1.data;
			piece_last = (job_s1.tail == TAIL_NONE);
		end else begin
			case (job_s1.tail)
				TAIL_ANSWER: begin
					item_byte  = answer_byte(ans_idx_s1, gateway_ip_q);
					item_end   = (ans_idx_s1 == ANS_IDX_W'(ANSWER_BYTES - 1));
					piece_last = item_end;
				end
				TAIL_DROP: begin
					item_end   = 1'b1;
					item_drop  = 1'b1;
					piece_last = 1'b1;
				end
				default: piece_last = 1'b1;
			endcase
		end
	end

	assign out_free    = !reply_valid || !reply_stall;
	assign move        = job_v_s1 && out_free;
	assign done        = move && piece_last;
	assign query_stall = job_v_s1 && !done;
	assign accept      = query_valid && !query_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_v_s1 <= 1'b0;
		end else if (accept) begin
			job_v_s1 <= job.has_byte || (job.tail != TAIL_NONE);
		end else if (done) begin
			job_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1     <= job;
			ans_idx_s1 <= '0;
		end else if (move) begin
			if (job_s1.has_byte)
				job_s1.has_byte <= 1'b0;
			else
				ans_idx_s1 <= ans_idx_s1 + ANS_IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			reply_valid <= 1'b0;
		else if (move)
			reply_valid <= 1'b1;
		else if (!reply_stall)
			reply_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (move) begin
			reply_byte   <= item_byte;
			end_of_reply <= item_end;
			dropped      <= item_drop;
		end
	end

endmodule

// ===== rtl/dqr_parser.sv =====
// Query parser: header rewrite and first-question walk, one byte per transfer.
// Depends on dqr_pkg. Holds the per-query parse state.
module dqr_parser #(
	parameter int QUERY_LIMIT = 496
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    query_byte,
	input  logic          end_of_query,
	output dqr_pkg::job_t job
);
	import dqr_pkg::*;

	localparam int POS_W = $clog2(QUERY_LIMIT + 1);

	logic [POS_W-1:0] pos_q, pos_d;
	phase_t           phase_q, phase_d;
	logic [5:0]       remain_q, remain_d;
	logic             qc_nz_q, qc_nz_d;
	logic             send;
	logic [7:0]       emit;
	logic [5:0]       remain_dec;

	assign remain_dec = remain_q - 6'd1;

	always_comb begin
		pos_d    = pos_q;
		phase_d  = phase_q;
		remain_d = remain_q;
		qc_nz_d  = qc_nz_q;
		send     = 1'b0;
		emit     = query_byte;

		if (pos_q < POS_W'(QUERY_LIMIT)) begin
			pos_d = pos_q + POS_W'(1);
			case (phase_q)
				PH_HEADER: begin
					send = 1'b1;
					case (pos_q)
						POS_W'(2): emit = (query_byte | 8'h80) & 8'hFD; // QR set, TC clear
						POS_W'(3): emit = query_byte | 8'h80;            // RA set
						POS_W'(4): begin
							qc_nz_d = (query_byte != 8'h00);
							emit    = 8'h00;
						end
						POS_W'(5): begin
							emit = 8'h01;
							if (!qc_nz_q && query_byte == 8'h00) begin
								phase_d = PH_FAILED;
								send    = 1'b0;
							end
						end
						POS_W'(6):  emit = 8'h00;
						POS_W'(7):  emit = 8'h01;
						POS_W'(8), POS_W'(9), POS_W'(10), POS_W'(11): emit = 8'h00;
						default: emit = query_byte;
					endcase
					if (phase_d == PH_HEADER && pos_q == POS_W'(HEADER_BYTES - 1))
						phase_d = PH_LABEL_LEN;
				end
				PH_LABEL_LEN: begin
					if (query_byte == 8'h00) begin
						phase_d  = PH_TAIL;
						remain_d = 6'd4;
						send     = 1'b1;
					end else if (query_byte[7:6] != 2'b00) begin
						phase_d = PH_FAILED;
					end else begin
						phase_d  = PH_LABEL_BODY;
						remain_d = query_byte[5:0];
						send     = 1'b1;
					end
				end
				PH_LABEL_BODY: begin
					send     = 1'b1;
					remain_d = remain_dec;
					if (remain_dec == 6'd0)
						phase_d = PH_LABEL_LEN;
				end
				PH_TAIL: begin
					send     = 1'b1;
					remain_d = remain_dec;
					if (remain_dec == 6'd0)
						phase_d = PH_DONE;
				end
				default: ;
			endcase
		end

		job.has_byte = send;
		job.data     = emit;
		if (!end_of_query)
			job.tail = TAIL_NONE;
		else if (phase_d == PH_DONE)
			job.tail = TAIL_ANSWER;
		else
			job.tail = TAIL_DROP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_HEADER;
			remain_q <= '0;
			qc_nz_q  <= 1'b0;
		end else if (take) begin
			if (end_of_query) begin
				pos_q    <= '0;
				phase_q  <= PH_HEADER;
				remain_q <= '0;
				qc_nz_q  <= 1'b0;
			end else begin
				pos_q    <= pos_d;
				phase_q  <= phase_d;
				remain_q <= remain_d;
				qc_nz_q  <= qc_nz_d;
			end
		end
	end

endmodule

// ===== dv/dns_query_redirect_responder_tb.sv =====
// Testbench for dns_query_redirect_responder: byte-level reply prediction and checking.
// Depends on dqr_pkg and the RTL; the sender and receiver idle and stall at random,
// with one long receiver hold-off that backs the block up.
module dns_query_redirect_responder_tb;
	import dqr_pkg::*;

	localparam int PACKET_BUFFER_BYTES = 512;
	localparam int QUERY_LIMIT         = PACKET_BUFFER_BYTES - ANSWER_BYTES;
	localparam int IDLE_LIMIT          = 3000;
	localparam int HOLD_CYCLES         = 300;
	localparam int RANDOM_BYTES        = 90;
	// name ptr 0xC00C, type A, class IN, TTL 30, rdlength 4
	localparam logic [95:0] A_RECORD_HEAD = 96'hC00C_0001_0001_0000_001E_0004;

	typedef struct packed {
		logic [7:0] data;
		logic       eoq;
	} query_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eor;
		logic       drop;
	} reply_item_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        query_valid = 1'b0;
	logic        query_stall;
	logic [7:0]  query_byte = 8'h00;
	logic        end_of_query = 1'b0;
	logic        reply_valid;
	logic        reply_stall = 1'b0;
	logic [7:0]  reply_byte;
	logic        end_of_reply;
	logic        dropped;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = 32'h0;

	dns_query_redirect_responder #(
		.PACKET_BUFFER_BYTES(PACKET_BUFFER_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.query_valid(query_valid),
		.query_stall(query_stall),
		.query_byte(query_byte),
		.end_of_query(end_of_query),
		.reply_valid(reply_valid),
		.reply_stall(reply_stall),
		.reply_byte(reply_byte),
		.end_of_reply(end_of_reply),
		.dropped(dropped),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	query_item_t pending_bytes[$];
	reply_item_t expected_replies[$];
	logic [7:0]  qbuf[$];
	bit          failed = 1'b0;
	int          random_bytes;

	// parser state mirrored for prediction
	logic [31:0] gw_model = 32'h0;
	logic [8:0]  q_pos = '0;
	phase_t      q_phase = PH_HEADER;
	logic [5:0]  q_remaining = '0;
	logic        q_qd_hi = 1'b0;

	task automatic predict_reply(input logic [7:0] b, input logic last);
		logic [8:0] p;
		logic [7:0] out_b;
		logic       send;
		p = q_pos;
		out_b = b;
		send = 1'b0;
		if (p < QUERY_LIMIT) begin
			q_pos = p + 9'd1;
			case (q_phase)
				PH_HEADER: begin
					send = 1'b1;
					case (p)
						9'd2: out_b = (b | 8'h80) & ~8'h02;
						9'd3: out_b = b | 8'h80;
						9'd4: begin
							q_qd_hi = (b != 8'h00);
							out_b = 8'h00;
						end
						9'd5: begin
							out_b = 8'h01;
							if (!q_qd_hi && b == 8'h00) begin
								q_phase = PH_FAILED;
								send = 1'b0;
							end
						end
						9'd7: out_b = 8'h01;
						9'd6, 9'd8, 9'd9, 9'd10, 9'd11: out_b = 8'h00;
						default: out_b = b;
					endcase
					if (q_phase == PH_HEADER && p == HEADER_BYTES - 1)
						q_phase = PH_LABEL_LEN;
				end
				PH_LABEL_LEN: begin
					if (b == 8'h00) begin
						q_phase = PH_TAIL;
						q_remaining = 6'd4;
						send = 1'b1;
					end else if (b[7:6] != 2'b00) begin
						q_phase = PH_FAILED;
					end else begin
						q_phase = PH_LABEL_BODY;
						q_remaining = b[5:0];
						send = 1'b1;
					end
				end
				PH_LABEL_BODY, PH_TAIL: begin
					send = 1'b1;
					q_remaining = q_remaining - 6'd1;
					if (q_remaining == 6'd0)
						q_phase = (q_phase == PH_TAIL) ? PH_DONE : PH_LABEL_LEN;
				end
				default: ;
			endcase
		end
		if (send)
			expected_replies.push_back('{out_b, 1'b0, 1'b0});
		if (last) begin
			if (q_phase == PH_DONE) begin
				for (int i = 0; i < 12; i++)
					expected_replies.push_back('{A_RECORD_HEAD[95 - 8 * i -: 8], 1'b0, 1'b0});
				for (int i = 0; i < 4; i++)
					expected_replies.push_back('{gw_model[31 - 8 * i -: 8], i == 3, 1'b0});
			end else begin
				expected_replies.push_back('{8'h00, 1'b1, 1'b1});
			end
			q_pos = '0;
			q_phase = PH_HEADER;
			q_remaining = '0;
			q_qd_hi = 1'b0;
		end
	endtask

	// sender: bursts of random length separated by random gaps
	int          snd_burst = 1;
	int          snd_gap = 0;
	query_item_t snd_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_valid <= 1'b0;
			query_byte <= 8'h00;
			end_of_query <= 1'b0;
		end else begin
			if (query_valid && !query_stall)
				predict_reply(query_byte, end_of_query);
			if (!query_valid || !query_stall) begin
				if (snd_gap > 0) begin
					snd_gap--;
					query_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					snd_item = pending_bytes.pop_front();
					query_valid <= 1'b1;
					query_byte <= snd_item.data;
					end_of_query <= snd_item.eoq;
					if (snd_burst > 1) begin
						snd_burst--;
					end else begin
						case ($urandom_range(0, 5))
							0: begin
								snd_burst = 200;
								snd_gap = 0;
							end
							1: begin
								snd_burst = $urandom_range(1, 40);
								snd_gap = $urandom_range(8, 30);
							end
							default: begin
								snd_burst = $urandom_range(1, 24);
								snd_gap = $urandom_range(0, 3);
							end
						endcase
					end
				end else begin
					query_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern changes per window, plus one long hold-off
	int rx_count = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_stall <= 1'b0;
		end else begin
			if (reply_valid && !reply_stall)
				rx_count++;
			if (hold_left > 0) begin
				hold_left--;
				reply_stall <= 1'b1;
			end else if (!hold_done && rx_count >= 250 && query_valid) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				reply_stall <= 1'b1;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(10, 60);
				end
				rx_left--;
				case (rx_mode)
					0: reply_stall <= 1'b0;
					1: reply_stall <= ($urandom_range(0, 3) == 0);
					2: reply_stall <= 1'($urandom_range(0, 1));
					default: reply_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	reply_item_t mon_exp;

	always @(posedge clk) begin
		if (arst_n && reply_valid && !reply_stall) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected reply transfer: reply_byte %02h end_of_reply %0b dropped %0b",
					reply_byte, end_of_reply, dropped);
				failed = 1'b1;
			end else begin
				mon_exp = expected_replies.pop_front();
				if (reply_byte !== mon_exp.data) begin
					$error("reply_byte: expected %02h, got %02h", mon_exp.data, reply_byte);
					failed = 1'b1;
				end
				if (end_of_reply !== mon_exp.eor) begin
					$error("end_of_reply: expected %0b, got %0b", mon_exp.eor, end_of_reply);
					failed = 1'b1;
				end
				if (dropped !== mon_exp.drop) begin
					$error("dropped: expected %0b, got %0b", mon_exp.drop, dropped);
					failed = 1'b1;
				end
			end
		end
	end

	int idle_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (query_valid && !query_stall) || (reply_valid && !reply_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("dns_query_redirect_responder_tb NOT OK");
			$finish;
		end
	end

	task automatic add_bytes(input int n);
		for (int i = 0; i < n; i++)
			qbuf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_header(input logic [15:0] qdcount);
		add_bytes(4);
		qbuf.push_back(qdcount[15:8]);
		qbuf.push_back(qdcount[7:0]);
		add_bytes(6);
	endtask

	task automatic add_label(input int len);
		qbuf.push_back(len[7:0]);
		add_bytes(len);
	endtask

	task automatic build_good();
		add_header(16'($urandom_range(1, 16'hFFFF)));
		repeat ($urandom_range(0, 4))
			add_label(($urandom_range(0, 9) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12));
		qbuf.push_back(8'h00);
		add_bytes(4);
	endtask

	// queue the assembled query for the sender, mark on the final byte
	task automatic send_query();
		for (int i = 0; i < qbuf.size(); i++)
			pending_bytes.push_back('{qbuf[i], i == qbuf.size() - 1});
		random_bytes += qbuf.size();
		qbuf.delete();
	endtask

	task automatic random_queries(input bit with_long);
		int pick;
		int cut;
		random_bytes = 0;
		if (with_long) begin
			// query running past the datagram limit
			if ($urandom_range(0, 1)) begin
				build_good();
				add_bytes($urandom_range(497, 520) - qbuf.size());
			end else begin
				add_header(16'($urandom_range(1, 16'hFFFF)));
				while (qbuf.size() < 505)
					add_label(63);
			end
			send_query();
			random_bytes = 0;
		end
		while (random_bytes < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				build_good();
				if ($urandom_range(0, 1))
					add_bytes($urandom_range(1, 12));
			end else if (pick < 72) begin
				build_good();
				cut = $urandom_range(1, qbuf.size() - 1);
				while (qbuf.size() > cut)
					void'(qbuf.pop_back());
			end else if (pick < 82) begin
				add_header(16'($urandom_range(1, 16'hFFFF)));
				repeat ($urandom_range(0, 2))
					add_label($urandom_range(1, 8));
				qbuf.push_back(8'($urandom_range(64, 255)));
				add_bytes($urandom_range(0, 10));
			end else if (pick < 88) begin
				add_header(16'h0000);
				add_label($urandom_range(1, 8));
				qbuf.push_back(8'h00);
				add_bytes(4);
			end else begin
				add_bytes($urandom_range(1, 40));
			end
			send_query();
		end
	endtask

	task automatic write_gateway(input logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gw_model = value;
	endtask

	// sampled on the falling edge so that all edge updates have settled
	task automatic wait_idle(input int settle);
		while (pending_bytes.size() != 0 || query_valid || expected_replies.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// flags all ones, longest label, gateway still at its reset value
		add_header(16'h0001);
		qbuf[2] = 8'hFF;
		qbuf[3] = 8'hFF;
		add_label(63);
		qbuf.push_back(8'h00);
		repeat (4) qbuf.push_back(8'hFF);
		send_query();
		// flags all zero, QDCOUNT high byte only, root name, trailing records
		add_header(16'h0100);
		qbuf[2] = 8'h00;
		qbuf[3] = 8'h00;
		qbuf.push_back(8'h00);
		repeat (4) qbuf.push_back(8'h00);
		add_bytes(3);
		send_query();
		// short queries
		qbuf.push_back(8'hFF);
		send_query();
		add_bytes(11);
		send_query();
		// header only, question missing
		add_header(16'h0001);
		send_query();
		// zero QDCOUNT
		add_header(16'h0000);
		add_label(3);
		qbuf.push_back(8'h00);
		add_bytes(4);
		send_query();
		// compression pointer where a length belongs, then a length of 64
		add_header(16'h0001);
		qbuf.push_back(8'hC0);
		qbuf.push_back(8'h0C);
		send_query();
		add_header(16'h0002);
		add_label(2);
		qbuf.push_back(8'd64);
		add_bytes(4);
		send_query();
		// question cut inside a label, then inside the type/class tail
		add_header(16'h0001);
		qbuf.push_back(8'd5);
		add_bytes(2);
		send_query();
		add_header(16'h0001);
		add_label(4);
		qbuf.push_back(8'h00);
		add_bytes(2);
		send_query();

		wait_idle(4);
		write_gateway(32'hFFFF_FFFF);
		random_queries(1'b0);
		wait_idle(4);
		write_gateway(32'h0000_0000);
		random_queries(1'b1);
		wait_idle(4);
		write_gateway($urandom);
		random_queries(1'b0);
		wait_idle(8);

		if (!failed)
			$display("dns_query_redirect_responder_tb OK");
		else
			$display("dns_query_redirect_responder_tb NOT OK");
		$finish;
	end

endmodule
